// ===== hw/rtl/ntc_pkg.sv =====
// Shared types, code constants and character table for the nibble text compactor.
// No dependencies.
`timescale 1ns / 1ps

package ntc_pkg;

    localparam logic [3:0] ESC_FIRST    = 4'd11;
    localparam logic [3:0] ESC_LAST     = 4'd15;
    localparam logic [7:0] END_CHAR     = 8'd0;
    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] SPECIAL_CHAR = 8'd255;
    localparam logic [7:0] PRINT_LOW    = 8'd32;
    localparam logic [7:0] PRINT_HIGH   = 8'd126;
    localparam logic [3:0] NEWLINE_CODE = 4'd2;
    localparam logic [3:0] SPECIAL_CODE = 4'd7;
    localparam logic [2:0] ROW_PLAIN    = 3'd0;
    localparam logic [2:0] ROW_RARE     = 3'd6;
    localparam int         SYM_COUNT    = 95;

    // row << 4 | code for printable characters
    localparam logic [7:0] SYM_MAP [SYM_COUNT] = '{
        8'h01, 8'h3C, 8'h3D, 8'h3E, 8'h66, 8'h65, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46,
        8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52,
        8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h3F, 8'h22, 8'h23, 8'h24,
        8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h30,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3A, 8'h3B, 8'h5B,
        8'h5C, 8'h5D, 8'h5E, 8'h61, 8'h60, 8'h03, 8'h10, 8'h11, 8'h12, 8'h04, 8'h13, 8'h14,
        8'h05, 8'h06, 8'h15, 8'h16, 8'h17, 8'h18, 8'h07, 8'h08, 8'h19, 8'h1A, 8'h1B, 8'h09,
        8'h0A, 8'h1C, 8'h1D, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h62, 8'h63, 8'h64, 8'h40
    };

    typedef struct packed {
        logic [1:0] n_codes;
        logic [3:0] code0;
        logic [3:0] code1;
        logic [3:0] code2;
        logic       bad;
        logic       eos;
    } ntc_codes_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_of_input;
        logic       string_end;
        logic       bad_char;
    } ntc_result_t;

endpackage

// ===== hw/rtl/nibble_text_compactor.sv =====
// Top level of the nibble text compactor: request register, encoder, packer, result buffer.
// Depends on ntc_pkg, ntc_encode and ntc_packer.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel s_valid/s_ready/s_char_code carries one character per request.
//   Output channel m_valid/m_ready carries packed bytes with m_last_of_input,
//   m_string_end and m_bad_char flags. A character yields zero, one or two bytes;
//   an unencodable character yields one byte of zero with m_bad_char set.
//   A request goes from the request register to the result buffer, then out.
//   Throughput: a request is taken every cycle while m_ready is high and each
//   gives at most one byte; a request giving two bytes holds the two-entry
//   result buffer until both are taken, the rate set by the single output port.
//   Reset (aresetn low, synchronous) empties the request register and the
//   result buffer and drops any pending half byte.
//   When m_ready is low the result buffer holds, the request register fills,
//   and s_ready falls until the buffer drains.
//
module nibble_text_compactor
    import ntc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_packed_byte,
    output logic       m_last_of_input,
    output logic       m_string_end,
    output logic       m_bad_char
);

    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    ntc_result_t res_reg [2];
    ntc_codes_t  codes;
    ntc_result_t res0;
    ntc_result_t res1;
    logic [1:0]  n_res;
    logic        pop;
    logic        load_ok;
    logic        consume;

    assign pop     = m_valid && m_ready;
    assign load_ok = (count_reg == 2'd0) || (count_reg == 2'd1 && m_ready);
    assign consume = in_valid_reg && load_ok;
    assign s_ready = !in_valid_reg || consume;

    ntc_encode u_encode (
        .char_code (char_reg),
        .codes     (codes)
    );

    ntc_packer u_packer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (consume),
        .codes   (codes),
        .res0    (res0),
        .res1    (res1),
        .n_res   (n_res)
    );

    always_comb begin
        count_next = count_reg;
        if (consume) begin
            count_next = n_res;
        end else if (pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            count_reg    <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_char_code;
        end
        if (consume) begin
            res_reg[0] <= res0;
            res_reg[1] <= res1;
        end else if (pop) begin
            res_reg[0] <= res_reg[1];
        end
    end

    assign m_valid         = (count_reg != 2'd0);
    assign m_packed_byte   = res_reg[0].packed_byte;
    assign m_last_of_input = res_reg[0].last_of_input;
    assign m_string_end    = res_reg[0].string_end;
    assign m_bad_char      = res_reg[0].bad_char;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_string_end |-> m_last_of_input && !m_bad_char)
        else $error("end of string byte not last of its request");

    a_bad_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_char |-> m_packed_byte == 8'd0 && m_last_of_input)
        else $error("bad character result malformed");

    a_load_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        consume |=> count_reg == $past(n_res))
        else $error("result buffer load lost entries");

endmodule

// ===== hw/rtl/ntc_encode.sv =====
// Character to nibble code sequence lookup.
// Depends on ntc_pkg.
`timescale 1ns / 1ps

module ntc_encode
    import ntc_pkg::*;
(
    input  logic [7:0] char_code,
    output ntc_codes_t codes
);

    logic [2:0] row;
    logic [3:0] code;
    logic       bad;
    logic [7:0] map_entry;
    logic [6:0] map_idx;

    assign map_idx   = 7'(char_code - PRINT_LOW);
    assign map_entry = SYM_MAP[map_idx];

    always_comb begin
        row  = ROW_PLAIN;
        code = 4'd0;
        bad  = 1'b0;
        priority if (char_code == END_CHAR) begin
            row  = ROW_PLAIN;
            code = 4'd0;
        end else if (char_code == NEWLINE_CHAR) begin
            row  = ROW_PLAIN;
            code = NEWLINE_CODE;
        end else if (char_code == SPECIAL_CHAR) begin
            row  = ROW_RARE;
            code = SPECIAL_CODE;
        end else if (char_code >= PRINT_LOW && char_code <= PRINT_HIGH) begin
            row  = map_entry[6:4];
            code = map_entry[3:0];
        end else begin
            bad = 1'b1;
        end
    end

    always_comb begin
        codes     = '0;
        codes.bad = bad;
        codes.eos = (char_code == END_CHAR);
        if (row == ROW_RARE) begin
            codes.n_codes = 2'd3;
            codes.code0   = ESC_LAST;
            codes.code1   = ESC_LAST;
            codes.code2   = code;
        end else if (row != ROW_PLAIN) begin
            codes.n_codes = 2'd2;
            codes.code0   = ESC_FIRST - 4'd1 + {1'b0, row};
            codes.code1   = code;
        end else begin
            codes.n_codes = 2'd1;
            codes.code0   = code;
        end
    end

endmodule

// ===== hw/rtl/ntc_packer.sv =====
// Nibble packer: pending half-byte state and byte assembly for one code sequence.
// Depends on ntc_pkg.
`timescale 1ns / 1ps

module ntc_packer
    import ntc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  ntc_codes_t  codes,
    output ntc_result_t res0,
    output ntc_result_t res1,
    output logic [1:0]  n_res
);

    logic       half_full_reg;
    logic       half_full_next;
    logic [3:0] held_reg;
    logic [3:0] held_next;

    always_comb begin
        logic [3:0] seq [3];
        logic       h;
        logic [3:0] hn;
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b;
        logic       emit;

        seq[0] = codes.code0;
        seq[1] = codes.code1;
        seq[2] = codes.code2;
        h   = half_full_reg;
        hn  = held_reg;
        cnt = 2'd0;
        b0  = 8'd0;
        b1  = 8'd0;
        for (int i = 0; i < 3; i++) begin
            emit = 1'b0;
            b    = 8'd0;
            if (2'(i) < codes.n_codes) begin
                if (h) begin
                    emit = 1'b1;
                    b    = {hn, seq[i]};
                    h    = 1'b0;
                    hn   = 4'd0;
                end else if (seq[i] == 4'd0) begin
                    emit = 1'b1;
                end else begin
                    h  = 1'b1;
                    hn = seq[i];
                end
            end
            if (emit) begin
                if (cnt == 2'd0) begin
                    b0  = b;
                    cnt = 2'd1;
                end else if (cnt == 2'd1) begin
                    b1  = b;
                    cnt = 2'd2;
                end
            end
        end

        res0 = '0;
        res1 = '0;
        if (codes.bad) begin
            n_res              = 2'd1;
            res0.bad_char      = 1'b1;
            res0.last_of_input = 1'b1;
            half_full_next     = half_full_reg;
            held_next          = held_reg;
        end else begin
            n_res            = cnt;
            res0.packed_byte = b0;
            res1.packed_byte = b1;
            if (cnt == 2'd1) begin
                res0.last_of_input = 1'b1;
                res0.string_end    = codes.eos;
            end
            if (cnt == 2'd2) begin
                res1.last_of_input = 1'b1;
                res1.string_end    = codes.eos;
            end
            half_full_next = h;
            held_next      = hn;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_full_reg <= 1'b0;
            held_reg      <= 4'd0;
        end else if (step) begin
            half_full_reg <= half_full_next;
            held_reg      <= held_next;
        end
    end

endmodule
